// ----- hw/rtl/lrbs_pkg.sv -----
// Shared types, register indexes and reset values for the link reconnect supervisor.
`default_nettype none

package lrbs_pkg;

	// Item operation codes
	typedef enum logic [1:0] {
		OP_POLL  = 2'd0,
		OP_UP    = 2'd1,
		OP_DOWN  = 2'd2,
		OP_START = 2'd3
	} op_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_BASE_BACKOFF  = 2'd0,
		REG_MAX_BACKOFF   = 2'd1,
		REG_RESET_AFTER   = 2'd2,
		REG_RESTART_AFTER = 2'd3
	} reg_idx_t;

	localparam logic [15:0] BASE_BACKOFF_RST  = 16'd5000;
	localparam logic [31:0] MAX_BACKOFF_RST   = 32'd60000;
	localparam logic [31:0] RESET_AFTER_RST   = 32'd300000;
	localparam logic [31:0] RESTART_AFTER_RST = 32'd900000;

	typedef struct packed {
		logic [15:0] base_backoff_ms;
		logic [31:0] max_backoff_ms;
		logic [31:0] reset_after_ms;
		logic [31:0] restart_after_ms;
	} cfg_t;

	typedef struct packed {
		op_t         operation;
		logic [31:0] now_ms;
		logic        link_up;
		logic [7:0]  disconnect_reason;
	} item_t;

	typedef struct packed {
		logic        connected;
		logic        reconnect_request;
		logic        driver_reset_request;
		logic        restart_request;
		logic [31:0] attempt_total;
		logic [31:0] reset_total;
		logic [7:0]  last_reason;
		logic [31:0] offline_ms;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lrbs_cfg_regs.sv -----
// Configuration register file for the link reconnect supervisor.
`default_nettype none

module lrbs_cfg_regs (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [31:0]         cfg_data,
	output lrbs_pkg::cfg_t           cfg
);

	lrbs_pkg::cfg_t cfg_q;

	// Always able to take a write
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Update the addressed register on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_backoff_ms  <= lrbs_pkg::BASE_BACKOFF_RST;
			cfg_q.max_backoff_ms   <= lrbs_pkg::MAX_BACKOFF_RST;
			cfg_q.reset_after_ms   <= lrbs_pkg::RESET_AFTER_RST;
			cfg_q.restart_after_ms <= lrbs_pkg::RESTART_AFTER_RST;
		end else if (cfg_valid) begin
			unique case (lrbs_pkg::reg_idx_t'(cfg_index))
				lrbs_pkg::REG_BASE_BACKOFF:  cfg_q.base_backoff_ms  <= cfg_data[15:0];
				lrbs_pkg::REG_MAX_BACKOFF:   cfg_q.max_backoff_ms   <= cfg_data;
				lrbs_pkg::REG_RESET_AFTER:   cfg_q.reset_after_ms   <= cfg_data;
				lrbs_pkg::REG_RESTART_AFTER: cfg_q.restart_after_ms <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lrbs_engine.sv -----
// Supervisor state registers and the per-item next-state and result logic.
`default_nettype none

module lrbs_engine (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lrbs_pkg::cfg_t      cfg,
	input  wire lrbs_pkg::item_t     item,
	input  wire logic                fire,
	output lrbs_pkg::result_t        result
);

	logic        started_q,   started_d;
	logic [31:0] down_since_q, down_since_d;
	logic [31:0] next_at_q,   next_at_d;
	logic [31:0] delay_q,     delay_d;
	logic [31:0] attempts_q,  attempts_d;
	logic [31:0] resets_q,    resets_d;
	logic [31:0] last_reset_q, last_reset_d;
	logic [7:0]  reason_q,    reason_d;

	logic [31:0] base_ext;
	logic [31:0] ds_poll;
	logic [31:0] next_poll;
	logic [31:0] off_poll;
	logic [31:0] since_reset;
	logic [31:0] until_due;
	logic [32:0] delay_dbl;
	logic        reset_ok;
	logic        due;
	logic        req_conn, req_reset, req_restart;

	assign base_ext = {16'd0, cfg.base_backoff_ms};

	// Poll view of the state once a fresh outage has been recorded
	assign ds_poll     = (down_since_q == 32'd0) ? item.now_ms : down_since_q;
	assign next_poll   = (down_since_q == 32'd0) ? item.now_ms : next_at_q;
	assign off_poll    = (ds_poll == 32'd0) ? 32'd0 : item.now_ms - ds_poll;
	assign since_reset = item.now_ms - last_reset_q;
	assign until_due   = item.now_ms - next_poll;
	assign delay_dbl   = {delay_q, 1'b0};
	assign reset_ok    = (off_poll >= cfg.reset_after_ms) &&
		((last_reset_q == 32'd0) || (since_reset >= cfg.reset_after_ms));
	assign due         = !until_due[31];

	// Work out the next state and the request flags
	always_comb begin
		started_d    = started_q;
		down_since_d = down_since_q;
		next_at_d    = next_at_q;
		delay_d      = delay_q;
		attempts_d   = attempts_q;
		resets_d     = resets_q;
		last_reset_d = last_reset_q;
		reason_d     = reason_q;
		req_conn     = 1'b0;
		req_reset    = 1'b0;
		req_restart  = 1'b0;
		unique case (item.operation)
			lrbs_pkg::OP_START: begin
				started_d = 1'b1;
				if (!item.link_up) begin
					down_since_d = item.now_ms;
					next_at_d    = item.now_ms + base_ext;
				end
				delay_d  = base_ext;
				req_conn = 1'b1;
			end
			lrbs_pkg::OP_UP: begin
				if (started_q) begin
					down_since_d = 32'd0;
					delay_d      = base_ext;
				end
			end
			lrbs_pkg::OP_DOWN: begin
				if (started_q) begin
					reason_d  = item.disconnect_reason;
					down_since_d = ds_poll;
					next_at_d = item.now_ms;
				end
			end
			lrbs_pkg::OP_POLL: begin
				if (started_q) begin
					if (item.link_up) begin
						if (down_since_q != 32'd0) begin
							down_since_d = 32'd0;
							delay_d      = base_ext;
						end
					end else begin
						down_since_d = ds_poll;
						next_at_d    = next_poll;
						if (off_poll >= cfg.restart_after_ms) begin
							req_restart = 1'b1;
						end else begin
							if (reset_ok) begin
								resets_d     = resets_q + 32'd1;
								last_reset_d = item.now_ms;
								req_reset    = 1'b1;
							end
							if (due) begin
								attempts_d = attempts_q + 32'd1;
								next_at_d  = item.now_ms + delay_q;
								delay_d    = (delay_dbl > {1'b0, cfg.max_backoff_ms}) ?
									cfg.max_backoff_ms : delay_dbl[31:0];
								req_conn   = 1'b1;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	// Build the result from the updated state
	always_comb begin
		result.connected            = item.link_up;
		result.reconnect_request    = req_conn;
		result.driver_reset_request = req_reset;
		result.restart_request      = req_restart;
		result.attempt_total        = attempts_d;
		result.reset_total          = resets_d;
		result.last_reason          = reason_d;
		result.offline_ms = (item.link_up || (down_since_d == 32'd0)) ? 32'd0 :
			item.now_ms - down_since_d;
	end

	// Commit the state when the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			down_since_q <= 32'd0;
			next_at_q    <= 32'd0;
			delay_q      <= {16'd0, lrbs_pkg::BASE_BACKOFF_RST};
			attempts_q   <= 32'd0;
			resets_q     <= 32'd0;
			last_reset_q <= 32'd0;
			reason_q     <= 8'd0;
		end else if (fire) begin
			started_q    <= started_d;
			down_since_q <= down_since_d;
			next_at_q    <= next_at_d;
			delay_q      <= delay_d;
			attempts_q   <= attempts_d;
			resets_q     <= resets_d;
			last_reset_q <= last_reset_d;
			reason_q     <= reason_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/link_reconnect_backoff_supervisor_core.sv -----
// Top level of the link reconnect supervisor with input and result registers.
//
// Use: each slave-side transfer carries one timestamped item (poll, link-up
// event, link-down event or start) and yields exactly one master-side
// transfer with the request flags, the attempt and reset counters, the last
// disconnect reason and the current offline time.
// The config channel writes the four limit registers by index; it is always
// ready and must only be used while no item is in flight.
// Path: an accepted item passes the input register, then the result register,
// before its result is offered on the master side.
// Throughput: one item per cycle while m_tready stays high. The state update is a
// single pass of subtract/compare logic between the input register and the result
// register, so the next item sees the state that the last item committed.
// Stall: while the result register holds an untaken result, one more item
// waits in the input register; s_tready drops only when both are full.
// Reset: arst_n empties both registers, clears the supervisor state (not started,
// link up, counters zero, delay at its default) and restores the config
// registers to their default limits.
`default_nettype none

module link_reconnect_backoff_supervisor_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [47:0]   s_tdata,   // now_ms, link_up, disconnect_reason, zero pad
	input  wire logic [1:0]    s_tuser,   // operation
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [111:0]       m_tdata,   // connected, reconnect_request,
	                                      // driver_reset_request, restart_request,
	                                      // attempt_total, reset_total, last_reason,
	                                      // offline_ms, zero pad
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [31:0]   cfg_data
);

	lrbs_pkg::cfg_t    cfg;
	lrbs_pkg::item_t   item_s1;
	lrbs_pkg::result_t result;
	lrbs_pkg::result_t result_q;
	logic              valid_s1;
	logic              advance;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	lrbs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Hold the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.operation         <= lrbs_pkg::op_t'(s_tuser);
			item_s1.now_ms            <= s_tdata[31:0];
			item_s1.link_up           <= s_tdata[32];
			item_s1.disconnect_reason <= s_tdata[40:33];
		end
	end

	lrbs_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.fire   (advance),
		.result (result)
	);

	// Hold the result until the downstream transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tdata = {4'd0,
		result_q.offline_ms,
		result_q.last_reason,
		result_q.reset_total,
		result_q.attempt_total,
		result_q.restart_request,
		result_q.driver_reset_request,
		result_q.reconnect_request,
		result_q.connected};

endmodule

`default_nettype wire

// ----- hw/rtl/lrbs_checker.sv -----
// Port-level checks for the link reconnect supervisor, bound to the top level.
`default_nettype none

module lrbs_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	input  wire logic          s_tready,
	input  wire logic          m_tvalid,
	input  wire logic          m_tready,
	input  wire logic [111:0]  m_tdata
);

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

	// An accepted item is followed by a result on offer on the master side
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> ##2 m_tvalid)
		else $error("accepted item produced no result");

	// A restart request stands alone
	a_restart_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[3]) |-> (!m_tdata[1] && !m_tdata[2] && !m_tdata[0]))
		else $error("restart request combined with other requests");

	// A connected link reports no offline time
	a_offline_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[107:76] == 32'd0))
		else $error("offline time reported while connected");

endmodule

bind link_reconnect_backoff_supervisor_core lrbs_checker u_lrbs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
